/* sv/svip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svip_pkg
// Shared widths, request codes and multiplier sizes for the sample voice.
// ----------------------------------------------------------------------------
package svip_pkg;

  localparam int FRAME_DEPTH   = 65536;
  localparam int ADDR_W        = 16;
  localparam int FRAMES_W      = 17;
  localparam int SAMPLE_W      = 16;
  localparam int FRAC_W        = 16;
  localparam int POS_W         = 33;
  localparam int RATE_W        = 24;
  localparam int GAIN_W        = 16;
  localparam int MIX_W         = 24;
  localparam int GAIN_SHIFT    = 15;

  // Shared multiplier: signed operands wide enough for a sample difference
  // and for an unsigned gain or fraction with a zero sign bit.
  localparam int MUL_W         = SAMPLE_W + 1;
  localparam int PROD_W        = 2 * MUL_W;

  // Request kinds carried on s_tuser
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;
  localparam logic [1:0] MODE_RENDER = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_RATE    = 2'd0;
  localparam logic [1:0] REG_GAIN    = 2'd1;
  localparam logic [1:0] REG_FRAMES  = 2'd2;

endpackage

/* sv/svip_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svip_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module svip_mul
  import svip_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

/* sv/sample_voice_interpolating_player.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_interpolating_player
// Stereo sample playback voice with linear interpolation, gain and mix-in.
// ----------------------------------------------------------------------------
// Each request on the slave stream gives exactly one result on the master
// stream. Load, start and stop requests, and render requests that find the
// voice idle or at the end of its sample, finish in the cycle they are taken
// and register their result as they are taken. A render request that plays a frame
// makes two reads of the single read port of the frame memory
// (frame at the integer position, then the next frame), then four passes
// through one shared 17x17 multiplier (left and right interpolation, left
// and right gain), the last two each followed by a saturating 24-bit add into
// the incoming mix. s_tready is high only while the sequencer is idle and the
// result register is free or being emptied, so one request is in work at a
// time; a new request can be taken in the same cycle that the previous result
// is taken downstream. Configuration writes are always taken (cfg_ready is
// tied high) and must come only while the voice has no request in work.
// The frame memory has no reset; frames must be loaded before they are read.
// ----------------------------------------------------------------------------
module sample_voice_interpolating_player
  import svip_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // [15:0] frame_address, [31:16] load_left, [47:32] load_right,
  // [71:48] mix_left_in, [95:72] mix_right_in
  input  logic [95:0]  s_tdata,
  // [1:0] mode
  input  logic [1:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [23:0] mix_left_out, [47:24] mix_right_out, [48] voice_playing,
  // [55:49] zero
  output logic [55:0]  m_tdata,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a request, read first frame
  localparam logic [2:0] S_RDA  = 3'd1;  // capture first frame, read next frame
  localparam logic [2:0] S_RDB  = 3'd2;  // capture frame differences
  localparam logic [2:0] S_ML   = 3'd3;  // multiply left difference by fraction
  localparam logic [2:0] S_MR   = 3'd4;  // multiply right difference, finish left
  localparam logic [2:0] S_GL   = 3'd5;  // left gain, finish right value
  localparam logic [2:0] S_GR   = 3'd6;  // right gain, left mix out
  localparam logic [2:0] S_FIN  = 3'd7;  // right mix out, advance position

  logic [2:0]                state;

  // Configuration registers
  logic [RATE_W-1:0]         rate;
  logic [GAIN_W-1:0]         gain;
  logic [FRAMES_W-1:0]       frames_cfg;

  // Voice state
  logic [POS_W-1:0]          pos;
  logic                      playing;

  // Request fields
  logic [ADDR_W-1:0]         in_addr;
  logic [SAMPLE_W-1:0]       in_left;
  logic [SAMPLE_W-1:0]       in_right;
  logic signed [MIX_W-1:0]   in_mix_l;
  logic signed [MIX_W-1:0]   in_mix_r;

  // Held request data for a render
  logic signed [MIX_W-1:0]   mix_l;
  logic signed [MIX_W-1:0]   mix_r;
  logic [FRAC_W-1:0]         frac;
  logic                      interp;
  logic [ADDR_W-1:0]         nx_addr;

  // Datapath registers
  logic signed [SAMPLE_W-1:0] a_l;
  logic signed [SAMPLE_W-1:0] a_r;
  logic signed [MUL_W-1:0]    d_l;
  logic signed [MUL_W-1:0]    d_r;
  logic signed [SAMPLE_W-1:0] v_l;
  logic signed [SAMPLE_W-1:0] v_r;

  // Result register
  logic signed [MIX_W-1:0]   out_l;
  logic signed [MIX_W-1:0]   out_r;
  logic                      out_play;

  // Frame memory: right sample in the upper half, left in the lower half
  logic [2*SAMPLE_W-1:0]     frame_mem [FRAME_DEPTH];
  logic [2*SAMPLE_W-1:0]     rd_data;
  logic [ADDR_W-1:0]         rd_addr;
  logic                      mem_we;

  // Shared multiplier
  logic signed [MUL_W-1:0]   op_a;
  logic signed [MUL_W-1:0]   op_b;
  logic signed [PROD_W-1:0]  prod;

  // Decode
  logic                      accept;
  logic                      out_free;
  logic                      res_load;
  logic [FRAMES_W-1:0]       frames;
  logic [FRAMES_W-1:0]       idx;
  logic [FRAMES_W:0]         idx_inc;
  logic                      active;
  logic                      interp_n;
  logic signed [SAMPLE_W-1:0] lerp_v;
  logic signed [MIX_W-1:0]   mix_sum;
  logic signed [MIX_W-1:0]   mix_sel;

  assign in_addr  = s_tdata[15:0];
  assign in_left  = s_tdata[31:16];
  assign in_right = s_tdata[47:32];
  assign in_mix_l = s_tdata[71:48];
  assign in_mix_r = s_tdata[95:72];

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;

  assign m_tdata = {7'd0, out_play, out_r, out_l};

  // Frame count clamps to the memory depth
  assign frames = (frames_cfg > FRAMES_W'(FRAME_DEPTH)) ? FRAMES_W'(FRAME_DEPTH) : frames_cfg;
  assign idx      = pos[POS_W-1:FRAC_W];
  assign idx_inc  = {1'b0, idx} + 1'b1;
  assign active   = playing && (idx < frames);
  assign interp_n = idx_inc < {1'b0, frames};

  // A result is ready when a request finishes on acceptance or the render ends
  assign res_load = (accept && !((s_tuser == MODE_RENDER) && active)) || (state == S_FIN);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rate       <= RATE_W'(65536);
      gain       <= GAIN_W'(32768);
      frames_cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RATE:   rate       <= cfg_data[RATE_W-1:0];
        REG_GAIN:   gain       <= cfg_data[GAIN_W-1:0];
        REG_FRAMES: frames_cfg <= cfg_data[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  assign mem_we  = accept && (s_tuser == MODE_LOAD);
  // Read the frame at the integer position while idle, the next one after
  assign rd_addr = (state == S_RDA) ? nx_addr : idx[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[in_addr] <= {in_right, in_left};
    end
    rd_data <= frame_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier operand select
  // ---------------------------------------------------------------------------
  always_comb begin
    case (state)
      S_ML: begin
        op_a = d_l;
        op_b = $signed({1'b0, frac});
      end
      S_MR: begin
        op_a = d_r;
        op_b = $signed({1'b0, frac});
      end
      S_GL: begin
        op_a = {v_l[SAMPLE_W-1], v_l};
        op_b = $signed({1'b0, gain});
      end
      S_GR: begin
        op_a = {v_r[SAMPLE_W-1], v_r};
        op_b = $signed({1'b0, gain});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  svip_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // ---------------------------------------------------------------------------
  // Post-multiply arithmetic
  // ---------------------------------------------------------------------------
  // Interpolated value: a + round(diff * frac / 2^F); the true value always
  // lies between the two frames, so the sample width holds it.
  logic signed [PROD_W-1:0] lerp_rnd;
  logic signed [SAMPLE_W-1:0] lerp_base;
  assign lerp_rnd  = prod + PROD_W'(1 << (FRAC_W - 1));
  assign lerp_base = (state == S_MR) ? a_l : a_r;
  assign lerp_v    = lerp_base + lerp_rnd[FRAC_W+SAMPLE_W-1:FRAC_W];

  // Gain scaling with rounding, then add into the mix and saturate
  localparam int SCALED_W = PROD_W - GAIN_SHIFT;
  localparam int SUM_W    = MIX_W + 1;
  logic signed [PROD_W-1:0]   gain_rnd;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SUM_W-1:0]    sum;
  assign gain_rnd = prod + PROD_W'(1 << (GAIN_SHIFT - 1));
  assign scaled   = gain_rnd[PROD_W-1:GAIN_SHIFT];
  assign mix_sel  = (state == S_GR) ? mix_l : mix_r;
  assign sum = {{(SUM_W-MIX_W){mix_sel[MIX_W-1]}}, mix_sel}
             + {{(SUM_W-SCALED_W){scaled[SCALED_W-1]}}, scaled};

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((1 << (MIX_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(1 << (MIX_W - 1));

  always_comb begin
    if (sum > SUM_MAX) begin
      mix_sum = {1'b0, {(MIX_W-1){1'b1}}};
    end else if (sum < SUM_MIN) begin
      mix_sum = {1'b1, {(MIX_W-1){1'b0}}};
    end else begin
      mix_sum = sum[MIX_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and voice state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos      <= '0;
      playing  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // raise valid for a finished request, drop it once taken
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (s_tuser)
              MODE_LOAD: ;
              MODE_START: begin
                if (frames != '0) begin
                  pos     <= '0;
                  playing <= 1'b1;
                end
              end
              MODE_STOP: begin
                pos     <= '0;
                playing <= 1'b0;
              end
              MODE_RENDER: begin
                if (active) begin
                  state <= S_RDA;
                end else begin
                  // idle or past the last frame: pass the mix through
                  playing <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: state <= S_ML;
        S_ML:  state <= S_MR;
        S_MR:  state <= S_GL;
        S_GL:  state <= S_GR;
        S_GR:  state <= S_FIN;
        S_FIN: begin
          pos   <= pos + POS_W'(rate);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath and result payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          mix_l   <= in_mix_l;
          mix_r   <= in_mix_r;
          frac    <= pos[FRAC_W-1:0];
          interp  <= interp_n;
          nx_addr <= interp_n ? idx_inc[ADDR_W-1:0] : idx[ADDR_W-1:0];
          if (s_tuser == MODE_RENDER) begin
            out_l    <= in_mix_l;
            out_r    <= in_mix_r;
            out_play <= 1'b0;
          end else begin
            out_l <= '0;
            out_r <= '0;
            case (s_tuser)
              MODE_START: out_play <= (frames != '0) ? 1'b1 : playing;
              MODE_STOP:  out_play <= 1'b0;
              default:    out_play <= playing;
            endcase
          end
        end
      end
      S_RDA: begin
        a_l <= rd_data[SAMPLE_W-1:0];
        a_r <= rd_data[2*SAMPLE_W-1:SAMPLE_W];
      end
      S_RDB: begin
        // last frame holds without interpolation: zero difference
        if (interp) begin
          d_l <= {rd_data[SAMPLE_W-1], rd_data[SAMPLE_W-1:0]}
               - {a_l[SAMPLE_W-1], a_l};
          d_r <= {rd_data[2*SAMPLE_W-1], rd_data[2*SAMPLE_W-1:SAMPLE_W]}
               - {a_r[SAMPLE_W-1], a_r};
        end else begin
          d_l <= '0;
          d_r <= '0;
        end
      end
      S_MR:  v_l   <= lerp_v;
      S_GL:  v_r   <= lerp_v;
      S_GR:  out_l <= mix_sum;
      S_FIN: begin
        out_r    <= mix_sum;
        out_play <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* test/sample_voice_interpolating_player_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_interpolating_player_tb
// Self-checking bench for the stereo interpolating sample voice.
// ----------------------------------------------------------------------------
// A mix ledger keeps its own copy of the frame memory, the play position, the
// playing flag and the three registers, and works out the mix result of each
// request when the voice accepts it. Each result beat is compared with the
// oldest pending mix. A short directed run covers the empty sample, the idle
// render, saturation both ways, the last-frame hold, the end of the sample, the
// zero rate, the oversized frame count and a load while playing. Random phases
// then sweep the registers through their extremes. Before each render the
// bench loads any frame the voice is about to read, so no unloaded frame is
// ever fetched. Both streams stall in random bursts except in the last phase.
// ----------------------------------------------------------------------------
module sample_voice_interpolating_player_tb;
  import svip_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 75;

  // One result beat, laid out as the low bits of m_tdata.
  typedef struct packed {
    logic        playing;
    logic [23:0] right;
    logic [23:0] left;
  } mix_beat_t;

  // Tracks voice state and the mix results still owed by the block.
  class voice_mix_ledger;
    logic [RATE_W-1:0]          rate;
    logic [GAIN_W-1:0]          gain;
    logic [FRAMES_W-1:0]        frame_count;
    logic [POS_W-1:0]           position;
    bit                         playing;
    logic signed [SAMPLE_W-1:0] left_mem  [FRAME_DEPTH];
    logic signed [SAMPLE_W-1:0] right_mem [FRAME_DEPTH];
    bit                         loaded    [FRAME_DEPTH];
    mix_beat_t                  pending_mixes [$];
    int                         errors;

    function new();
      rate        = 24'd65536;
      gain        = 16'd32768;
      frame_count = '0;
      position    = '0;
      playing     = 1'b0;
      errors      = 0;
    endfunction

    // Counts above the memory depth behave as the full depth.
    function int usable_frames();
      return (frame_count > FRAME_DEPTH) ? FRAME_DEPTH : int'(frame_count);
    endfunction

    function void write_register(logic [1:0] index, logic [23:0] value);
      case (index)
        REG_RATE:   rate        = value[RATE_W-1:0];
        REG_GAIN:   gain        = value[GAIN_W-1:0];
        REG_FRAMES: frame_count = value[FRAMES_W-1:0];
        default: ;
      endcase
    endfunction

    // Report a frame the next render would read before it was ever loaded.
    function bit unloaded_frame(output int addr);
      int idx;
      int frames;
      frames = usable_frames();
      addr   = 0;
      if (!playing) return 1'b0;
      idx = int'(position >> FRAC_W);
      if (idx >= frames) return 1'b0;
      if (!loaded[idx]) begin
        addr = idx;
        return 1'b1;
      end
      if (idx + 1 < frames && !loaded[idx + 1]) begin
        addr = idx + 1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Blend two frames by the fraction, then apply the Q1.15 gain with rounding.
    function longint scaled_voice(longint a, longint b, longint frac, bit interp);
      longint v;
      v = a;
      if (interp)
        v = (a * ((longint'(1) << FRAC_W) - frac) + b * frac
             + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
      return (v * longint'(gain) + (longint'(1) << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
    endfunction

    function logic [23:0] saturated_mix(longint mix, longint add);
      longint sum;
      sum = mix + add;
      if (sum > 64'sd8388607)  sum = 64'sd8388607;
      if (sum < -64'sd8388608) sum = -64'sd8388608;
      return sum[23:0];
    endfunction

    function void take_request(logic [1:0] mode, logic [95:0] data);
      logic signed [23:0] mix_l;
      logic signed [23:0] mix_r;
      mix_beat_t          want;
      int                 frames;
      int                 idx;
      int                 nxt;
      bit                 interp;
      longint             frac;
      mix_l  = data[71:48];
      mix_r  = data[95:72];
      frames = usable_frames();
      want   = '0;
      case (mode)
        MODE_LOAD: begin
          // A 16-bit address always falls inside the memory.
          left_mem[data[15:0]]  = data[31:16];
          right_mem[data[15:0]] = data[47:32];
          loaded[data[15:0]]    = 1'b1;
        end
        MODE_START: begin
          if (frames != 0) begin
            position = '0;
            playing  = 1'b1;
          end
        end
        MODE_STOP: begin
          playing  = 1'b0;
          position = '0;
        end
        MODE_RENDER: begin
          want.left  = mix_l;
          want.right = mix_r;
          if (playing) begin
            idx = int'(position >> FRAC_W);
            if (idx >= frames) begin
              playing = 1'b0;
            end else begin
              frac   = longint'(position[FRAC_W-1:0]);
              interp = (idx + 1) < frames;
              nxt    = interp ? idx + 1 : idx;
              want.left  = saturated_mix(mix_l, scaled_voice(left_mem[idx],
                                         left_mem[nxt], frac, interp));
              want.right = saturated_mix(mix_r, scaled_voice(right_mem[idx],
                                         right_mem[nxt], frac, interp));
              position = position + rate;
            end
          end
        end
        default: ;
      endcase
      want.playing = playing;
      pending_mixes.push_back(want);
    endfunction

    function void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_mix(logic [55:0] beat);
      mix_beat_t got;
      mix_beat_t want;
      got = mix_beat_t'(beat[48:0]);
      if (pending_mixes.size() == 0) begin
        $display("%0t: unrequested result, expected none, actual %h", $time, beat);
        errors++;
        return;
      end
      want = pending_mixes.pop_front();
      check_field("mix_left_out", want.left, got.left);
      check_field("mix_right_out", want.right, got.right);
      check_field("voice_playing", 24'(want.playing), 24'(got.playing));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = MODE_LOAD;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_RATE;
  logic [23:0] cfg_data = '0;

  voice_mix_ledger ledger = new();
  bit              traffic_gaps = 1'b1;

  // Register settings per random phase: rate, gain, frame count.
  logic [23:0] phase_rate   [PHASES] = '{24'h010000, 24'hFFFFFF, 24'h000100, 24'h000000,
                                         24'h018000, 24'h00A3D7, 24'h123456, 24'h010000,
                                         24'h010000, 24'h00C000};
  logic [23:0] phase_gain   [PHASES] = '{24'd32768, 24'd32768, 24'd20000, 24'd0,
                                         24'd65535, 24'd40000, 24'd12345, 24'd32768,
                                         24'd32768, 24'd32768};
  logic [23:0] phase_frames [PHASES] = '{24'd16, 24'd65536, 24'd4, 24'd8,
                                         24'd1, 24'd200, 24'd65536, 24'd64,
                                         24'd131071, 24'd32};

  sample_voice_interpolating_player dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sample result beats on the rising edge and check them in order.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      ledger.match_mix(m_tdata);
  end

  // Drop m_tready in random bursts while gaps are enabled.
  initial begin : result_sink
    int stall;
    m_tready = 1'b1;
    stall    = 0;
    forever begin
      @(negedge clk);
      if (stall == 0 && traffic_gaps && $urandom_range(0, 7) == 0)
        stall = $urandom_range(1, 15);
      if (stall != 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Abort a hung run.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_mix();
    case ($urandom_range(0, 7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'($urandom_range(0, 64) - 32);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [95:0] pack_request(logic [15:0] addr, logic [15:0] left,
                                               logic [15:0] right, logic [23:0] mix_l,
                                               logic [23:0] mix_r);
    return {mix_r, mix_l, right, left, addr};
  endfunction

  // Present one request from a falling edge and hold it until it is taken.
  task automatic send_request(input logic [1:0] mode, input logic [95:0] data);
    if (traffic_gaps && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 15)) @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = mode;
    s_tdata  = data;
    do @(posedge clk); while (!s_tready);
    ledger.take_request(mode, data);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic write_register(input logic [1:0] index, input logic [23:0] value);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    ledger.write_register(index, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold until every owed result is back, then let the pipeline drain.
  task automatic settle();
    while (ledger.pending_mixes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [23:0] rate, input logic [23:0] gain,
                           input logic [23:0] frames);
    settle();
    write_register(REG_RATE, rate);
    write_register(REG_GAIN, gain);
    write_register(REG_FRAMES, frames);
  endtask

  // Mostly well-formed playback: load whatever the next render reads, then
  // favor renders while playing and starts while idle.
  task automatic random_item();
    int          addr;
    int          roll;
    int          last;
    logic [95:0] data;
    data = pack_request(16'($urandom), pick_sample(), pick_sample(), pick_mix(), pick_mix());
    roll = $urandom_range(0, 19);
    last = (ledger.usable_frames() > 0) ? ledger.usable_frames() - 1 : 0;
    if (ledger.unloaded_frame(addr)) begin
      data[15:0] = 16'(addr);
      send_request(MODE_LOAD, data);
    end else if (ledger.playing) begin
      if (roll == 0) begin
        send_request(MODE_START, data);
      end else if (roll == 1) begin
        send_request(MODE_STOP, data);
      end else if (roll < 4) begin
        // overwrite a frame inside the sample while it plays
        data[15:0] = 16'($urandom_range(0, last));
        send_request(MODE_LOAD, data);
      end else if (roll < 6) begin
        send_request(MODE_LOAD, data);
      end else begin
        send_request(MODE_RENDER, data);
      end
    end else begin
      if (roll < 8)
        send_request(MODE_START, data);
      else if (roll < 10)
        send_request(MODE_STOP, data);
      else if (roll < 14)
        send_request(MODE_LOAD, data);
      else
        send_request(MODE_RENDER, data);
    end
  endtask

  initial begin : stimulus
    int p;
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty sample: start is ignored, render passes the mix through.
    send_request(MODE_START, pack_request(16'd0, 16'd0, 16'd0, 24'd0, 24'd0));
    send_request(MODE_RENDER, pack_request(16'd0, 16'd0, 16'd0, 24'h7FFFFF, 24'h800000));
    send_request(MODE_STOP, pack_request(16'd0, 16'd0, 16'd0, 24'd0, 24'd0));

    // Three frames at 0.75 rate: saturate both ways, hold the last frame, run off the end.
    configure(24'h00C000, 24'd32768, 24'd3);
    send_request(MODE_LOAD, pack_request(16'd0, 16'h7FFF, 16'h8000, 24'd0, 24'd0));
    send_request(MODE_LOAD, pack_request(16'd1, 16'h8000, 16'h7FFF, 24'd0, 24'd0));
    send_request(MODE_LOAD, pack_request(16'd2, 16'd100, -16'sd100, 24'd0, 24'd0));
    send_request(MODE_LOAD, pack_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd0, 24'd0));
    send_request(MODE_START, pack_request(16'd0, 16'd0, 16'd0, 24'd0, 24'd0));
    send_request(MODE_RENDER, pack_request(16'd0, 16'd0, 16'd0, 24'h7FFFFF, 24'h7FFFFF));
    send_request(MODE_RENDER, pack_request(16'd0, 16'd0, 16'd0, 24'h800000, 24'h800000));
    repeat (4)
      send_request(MODE_RENDER, pack_request(16'd0, 16'd0, 16'd0, 24'd0, 24'h000123));

    // Zero rate, gain near two, oversized frame count; reload while playing.
    configure(24'h000000, 24'd65535, 24'd131071);
    send_request(MODE_START, pack_request(16'd0, 16'd0, 16'd0, 24'd0, 24'd0));
    send_request(MODE_RENDER, pack_request(16'd0, 16'd0, 16'd0, 24'h800000, 24'h7FFFFF));
    send_request(MODE_LOAD, pack_request(16'd0, 16'h8000, 16'h7FFF, 24'd0, 24'd0));
    send_request(MODE_RENDER, pack_request(16'd0, 16'd0, 16'd0, 24'h800000, 24'h7FFFFF));
    send_request(MODE_RENDER, pack_request(16'd0, 16'd0, 16'd0, 24'd0, 24'd0));
    send_request(MODE_STOP, pack_request(16'd0, 16'd0, 16'd0, 24'd0, 24'd0));
    send_request(MODE_RENDER, pack_request(16'd0, 16'd0, 16'd0, 24'h000042, 24'hFFFFBE));

    for (p = 0; p < PHASES; p++) begin
      if (p == 7) begin
        phase_rate[p]   = 24'($urandom_range(0, 24'h030000));
        phase_gain[p]   = 24'($urandom_range(0, 65535));
        phase_frames[p] = 24'($urandom_range(1, 300));
      end
      // run the final phase with both streams flowing freely
      if (p == PHASES - 1)
        traffic_gaps = 1'b0;
      configure(phase_rate[p], phase_gain[p], phase_frames[p]);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold the sender until all results are back in some phases
        if (n == ITEMS_PER_PHASE / 2 && p % 3 == 1)
          settle();
        random_item();
      end
    end

    settle();
    if (ledger.errors == 0 && ledger.pending_mixes.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
